### hw/rtl/dpmt_pkg.sv
// Package with the constants, types and mode table of the DEC private mode tracker.
package dpmt_pkg;

    localparam int DATA_W       = 8;
    localparam int MODE_W       = 7;
    localparam int TDATA_W      = 8;
    localparam int ACC_W        = 16;
    localparam int PROD_W       = ACC_W + 4;
    localparam int MAX_PARAMS   = 16;
    localparam int NUM_MODES    = 7;
    localparam int TABLE_MODES  = 7;
    localparam int ACTIVE_MODES = (NUM_MODES < TABLE_MODES) ? NUM_MODES : TABLE_MODES;
    localparam int COUNT_W      = $clog2(MAX_PARAMS + 1);

    localparam logic [PROD_W-1:0] ACC_MAX = PROD_W'(20'hFFFF);

    localparam logic [ACC_W-1:0] MODE_TABLE [TABLE_MODES] = '{
        16'd1000, 16'd1002, 16'd1003, 16'd1004, 16'd1006, 16'd1015, 16'd2004
    };

    localparam logic [DATA_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [DATA_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [DATA_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [DATA_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
    localparam logic [DATA_W-1:0] CH_SET   = 8'h68;
    localparam logic [DATA_W-1:0] CH_RESET = 8'h6C;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ESC     = 4'b0010,
        PH_BRACKET = 4'b0100,
        PH_PARAMS  = 4'b1000
    } phase_t;

endpackage

### hw/rtl/dec_private_mode_tracker_unit.sv
// Top level of the DEC private mode tracker: byte parser, mode flags and stream ports.
//
// The block watches a byte stream of terminal output for ESC [ ? params h/l
// sequences and keeps the on flags of seven tracked private modes.
// Input channel: s_axis_tdata carries one byte, s_axis_tlast marks the last
// byte of a read chunk; a partial sequence is dropped after such a byte.
// Output channel: one transaction per input byte; m_axis_tdata carries the
// mode flags after that byte, m_axis_tuser is high when the byte ended a
// set or reset sequence.
// From input acceptance to output valid, the byte sits in the input register,
// and the parser update is loaded into the output register once that register
// has room (it is empty or the receiver takes its transaction).
// Throughput is one byte per cycle while the receiver does not stall; the parser
// state update is combinational, with the multiply by ten of the decimal accumulator.
// When the receiver stalls, the output register holds its transaction and
// the input register can still take one more byte before s_axis_tready drops.
// Reset clears the parser to idle, all mode flags off and both registers
// empty.
module dec_private_mode_tracker_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dpmt_pkg::DATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [dpmt_pkg::TDATA_W-1:0] m_axis_tdata,  // [6:0] mode_flags, [7] zero
    output logic                        m_axis_tuser    // [0] sequence_applied
);

    logic                          in_valid_reg;
    logic [dpmt_pkg::DATA_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    logic [dpmt_pkg::TDATA_W-1:0]  out_data_reg;
    logic                          out_user_reg;

    dpmt_pkg::phase_t              phase_reg, phase_next;
    logic [dpmt_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                          digit_seen_reg, digit_seen_next;
    logic [dpmt_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [dpmt_pkg::MODE_W-1:0]   pending_reg, pending_next;
    logic [dpmt_pkg::MODE_W-1:0]   mode_on_reg, mode_on_next;

    logic                          out_slot;
    logic                          proc_fire;
    logic                          applied;
    logic                          commit_ok;
    logic [dpmt_pkg::MODE_W-1:0]   match;
    logic [dpmt_pkg::MODE_W-1:0]   pending_commit;
    logic [dpmt_pkg::COUNT_W-1:0]  count_commit;
    logic [dpmt_pkg::PROD_W-1:0]   prod;

    assign out_slot      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && out_slot;
    assign s_axis_tready = !in_valid_reg || out_slot;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb begin
        match = '0;
        for (int k = 0; k < dpmt_pkg::ACTIVE_MODES; k++) begin
            match[k] = (acc_reg == dpmt_pkg::MODE_TABLE[k]);
        end
    end

    // The digit value is the low nibble because '0' sits at 0x30.
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + dpmt_pkg::PROD_W'(in_byte_reg[3:0]);

    assign commit_ok      = digit_seen_reg
                          && (count_reg < dpmt_pkg::COUNT_W'(dpmt_pkg::MAX_PARAMS));
    assign pending_commit = pending_reg | (commit_ok ? match : '0);
    assign count_commit   = count_reg + dpmt_pkg::COUNT_W'(commit_ok);

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        count_next      = count_reg;
        pending_next    = pending_reg;
        mode_on_next    = mode_on_reg;
        applied         = 1'b0;

        case (phase_reg)
            dpmt_pkg::PH_ESC: begin
                if (in_byte_reg == dpmt_pkg::CH_ESC) begin
                    phase_next = dpmt_pkg::PH_ESC;
                end else if (in_byte_reg == dpmt_pkg::CH_LBRK) begin
                    phase_next = dpmt_pkg::PH_BRACKET;
                end else begin
                    phase_next = dpmt_pkg::PH_IDLE;
                end
            end
            dpmt_pkg::PH_BRACKET: begin
                if (in_byte_reg == dpmt_pkg::CH_QUEST) begin
                    phase_next      = dpmt_pkg::PH_PARAMS;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    count_next      = '0;
                    pending_next    = '0;
                end else if (in_byte_reg == dpmt_pkg::CH_ESC) begin
                    phase_next = dpmt_pkg::PH_ESC;
                end else begin
                    phase_next = dpmt_pkg::PH_IDLE;
                end
            end
            dpmt_pkg::PH_PARAMS: begin
                if (in_byte_reg inside {[dpmt_pkg::CH_ZERO:dpmt_pkg::CH_NINE]}) begin
                    acc_next        = (prod > dpmt_pkg::ACC_MAX) ? '1
                                    : prod[dpmt_pkg::ACC_W-1:0];
                    digit_seen_next = 1'b1;
                end else if (in_byte_reg == dpmt_pkg::CH_SEMI) begin
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    count_next      = count_commit;
                    pending_next    = pending_commit;
                end else if (in_byte_reg == dpmt_pkg::CH_SET
                             || in_byte_reg == dpmt_pkg::CH_RESET) begin
                    if (in_byte_reg == dpmt_pkg::CH_SET) begin
                        mode_on_next = mode_on_reg | pending_commit;
                    end else begin
                        mode_on_next = mode_on_reg & ~pending_commit;
                    end
                    applied         = 1'b1;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    count_next      = '0;
                    pending_next    = '0;
                    phase_next      = dpmt_pkg::PH_IDLE;
                end else begin
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                    count_next      = '0;
                    pending_next    = '0;
                    phase_next      = (in_byte_reg == dpmt_pkg::CH_ESC)
                                    ? dpmt_pkg::PH_ESC : dpmt_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = (in_byte_reg == dpmt_pkg::CH_ESC)
                           ? dpmt_pkg::PH_ESC : dpmt_pkg::PH_IDLE;
            end
        endcase

        if (in_last_reg) begin
            phase_next      = dpmt_pkg::PH_IDLE;
            acc_next        = '0;
            digit_seen_next = 1'b0;
            count_next      = '0;
            pending_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= dpmt_pkg::PH_IDLE;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            count_reg      <= '0;
            pending_reg    <= '0;
            mode_on_reg    <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_slot) begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc_fire) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                digit_seen_reg <= digit_seen_next;
                count_reg      <= count_next;
                pending_reg    <= pending_next;
                mode_on_reg    <= mode_on_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc_fire) begin
            out_data_reg <= {1'b0, mode_on_next};
            out_user_reg <= applied;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dpmt_pkg::COUNT_W'(dpmt_pkg::MAX_PARAMS))
        else $error("Parameter count exceeds its limit.");

    a_chunk_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |=>
        (phase_reg == dpmt_pkg::PH_IDLE && count_reg == '0 && !digit_seen_reg
         && pending_reg == '0))
        else $error("Parser state survived the end of a chunk.");

    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !(proc_fire && applied)) |=> $stable(mode_on_reg))
        else $error("Mode flags changed without a terminated sequence.");

    a_out_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> (out_data_reg[dpmt_pkg::MODE_W-1:0] == mode_on_reg))
        else $error("Output flags differ from the tracked mode flags.");

endmodule
